@@ rtl/ffha_pkg.sv @@
// Shared codes and widths for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;
  localparam int GRAN_BYTES = 8;
  localparam int GRAN_SHIFT = 3;
  localparam int ADDR_W     = 16;
  localparam int SIZE_W     = 16;
  localparam int NEED_W     = 14;   // granules for the largest request, header included

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_RESIZE = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ZERO    = 2'd1,
    STAT_NOSPACE = 2'd2,
    STAT_IGNORED = 2'd3
  } status_t;
endpackage

@@ rtl/ffha_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ffha_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/first_fit_heap_allocator_unit.sv @@
// Requests that touch no header go straight to the result; the others walk the chain,
//   one header per cycle through the RAM read port.
// A resize that moves walks the chain three times (locate, first fit, then predecessor search).
// Throughput: one request at a time; the next is taken while a result waits.
// Reset: synchronous; chain head emulated by a flag until first written, so no
//   clearing pass. Other header words are undefined until written.
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int ZONE_BYTES = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic [SIZE_W-1:0]   req_size,
  input  logic [ADDR_W-1:0]   req_addr,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ADDR_W-1:0]   result_addr,
  output logic [1:0]          status,
  output logic                moved,
  output logic [ADDR_W-1:0]   copy_bytes
);
  localparam int G     = ZONE_BYTES / GRAN_BYTES;
  localparam int AW    = (G > 1) ? $clog2(G) : 1;
  localparam int LEN_W = $clog2(G + 1);
  localparam int HW    = LEN_W + 1;
  localparam int CNTW  = $clog2(G + 1);
  localparam int WW    = ((LEN_W > NEED_W) ? LEN_W : NEED_W) + 2;
  localparam logic [WW-1:0] G_W = WW'(G);
  localparam logic [HW-1:0] RESET_HDR = {1'b1, LEN_W'(G)};

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_WALK   = 8'b0000_0010,
    S_REL_NX = 8'b0000_0100,
    S_RSZ_NX = 8'b0000_1000,
    S_W0     = 8'b0001_0000,
    S_W1     = 8'b0010_0000,
    S_LOC2   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    WM_FIT  = 2'd0,
    WM_LOC1 = 2'd1,
    WM_LOC2 = 2'd2
  } walk_mode_t;

  state_t     state;
  walk_mode_t mode;

  logic [1:0]        type_q;
  logic              size_zero;
  logic [ADDR_W-1:0] addr_q;
  logic [WW-1:0]     need_w;
  logic [WW-1:0]     start;
  logic              reloc;
  logic [WW-1:0]     pos;
  logic [CNTW-1:0]   step_cnt;
  logic [CNTW-1:0]   block_count;
  logic [WW-1:0]     prev_pos;
  logic              has_prev;
  logic [HW-1:0]     prev_h;
  logic [LEN_W-1:0]  cur_len;
  logic [WW-1:0]     wa0, wa1;
  logic [HW-1:0]     wd0, wd1;
  logic              w0_en, w1_en, w_then_loc2;
  logic              h0_init, rd_zero;
  logic [ADDR_W-1:0] res_addr, res_copy;
  logic [1:0]        res_status;
  logic              res_moved;

  logic [HW-1:0]     ram_rdata, hdr_q;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [HW-1:0]     ram_wdata;

  logic              h_free;
  logic [WW-1:0]     h_len, pos_adv, nxt_pos, cur_w, prev_len;
  logic              live, nfree;
  logic [16:0]       need_sum;

  ffha_ram #(.WIDTH(HW), .DEPTH(G)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hdr_q    = (rd_zero && !h0_init) ? RESET_HDR : ram_rdata;
  assign h_free   = hdr_q[LEN_W];
  assign h_len    = WW'(hdr_q[LEN_W-1:0]);
  assign pos_adv  = pos + h_len;
  assign cur_w    = WW'(cur_len);
  assign nxt_pos  = start + cur_w;
  assign prev_len = WW'(prev_h[LEN_W-1:0]);
  assign live     = (step_cnt < block_count) && (pos < G_W);
  assign nfree    = (nxt_pos < G_W) && h_free;
  assign need_sum = {1'b0, req_size} + 17'd15;

  assign ram_raddr = (state == S_WALK) ? pos_adv[AW-1:0] : '0;
  assign ram_we    = ((state == S_W0) && w0_en) || ((state == S_W1) && w1_en);
  assign ram_waddr = (state == S_W0) ? wa0[AW-1:0] : wa1[AW-1:0];
  assign ram_wdata = (state == S_W0) ? wd0 : wd1;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      block_count <= CNTW'(1);
      h0_init     <= 1'b0;
      out_valid   <= 1'b0;
      rd_zero     <= 1'b0;
    end else begin
      rd_zero <= (ram_raddr == '0);
      if (ram_we && ram_waddr == '0) begin
        h0_init <= 1'b1;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            type_q     <= req_type;
            size_zero  <= (req_size == '0);
            addr_q     <= req_addr;
            need_w     <= WW'(need_sum[16:GRAN_SHIFT]);
            start      <= WW'(req_addr[ADDR_W-1:GRAN_SHIFT]) - WW'(1);
            reloc      <= 1'b0;
            res_addr   <= '0;
            res_moved  <= 1'b0;
            res_copy   <= '0;
            pos        <= '0;
            step_cnt   <= '0;
            has_prev   <= 1'b0;
            if (req_type == REQ_NONE) begin
              res_status <= STAT_IGNORED;
              state      <= S_DONE;
            end else if (req_type == REQ_ALLOC ||
                         (req_type == REQ_RESIZE && req_addr == '0)) begin
              if (req_size == '0) begin
                res_status <= STAT_ZERO;
                state      <= S_DONE;
              end else begin
                res_status <= STAT_OK;
                mode       <= WM_FIT;
                state      <= S_WALK;
              end
            end else if (req_addr == '0 || req_addr[GRAN_SHIFT-1:0] != '0) begin
              res_status <= STAT_IGNORED;
              state      <= S_DONE;
            end else begin
              res_status <= STAT_OK;
              mode       <= WM_LOC1;
              state      <= S_WALK;
            end
          end
        end

        S_WALK: begin
          if (!live || (mode != WM_FIT && pos != start && h_len == '0) ||
              (mode == WM_FIT && !(h_free && need_w <= h_len) && h_len == '0)) begin
            // chain exhausted without a match
            case (mode)
              WM_FIT: begin
                res_addr   <= '0;
                res_status <= STAT_NOSPACE;
                res_moved  <= 1'b0;
                res_copy   <= '0;
              end
              WM_LOC1: begin
                res_addr   <= '0;
                res_status <= STAT_IGNORED;
              end
              default: ;
            endcase
            state <= S_DONE;
          end else if (mode == WM_FIT && h_free && need_w <= h_len) begin
            if (h_len - need_w > WW'(1)) begin
              w0_en       <= 1'b1;
              wa0         <= pos + need_w;
              wd0         <= {1'b1, LEN_W'(h_len - need_w)};
              wd1         <= {1'b0, LEN_W'(need_w)};
              block_count <= block_count + CNTW'(1);
            end else begin
              w0_en <= 1'b0;
              wd1   <= {1'b0, LEN_W'(h_len)};
            end
            w1_en       <= 1'b1;
            wa1         <= pos;
            w_then_loc2 <= reloc;
            res_addr    <= {13'(pos + WW'(1)), 3'b000};
            res_status  <= STAT_OK;
            if (reloc) begin
              res_moved <= 1'b1;
              res_copy  <= {13'(cur_w - WW'(1)), 3'b000};
            end
            state <= S_W0;
          end else if (mode != WM_FIT && pos == start) begin
            if (mode == WM_LOC2) begin
              state <= S_REL_NX;
            end else if (h_free) begin
              res_status <= STAT_IGNORED;
              state      <= S_DONE;
            end else begin
              cur_len <= hdr_q[LEN_W-1:0];
              if (type_q == REQ_FREE || size_zero) begin
                res_status <= (type_q == REQ_RESIZE) ? STAT_ZERO : STAT_OK;
                state      <= S_REL_NX;
              end else begin
                res_addr <= addr_q;
                state    <= (need_w == h_len) ? S_DONE : S_RSZ_NX;
              end
            end
          end else begin
            prev_pos <= pos;
            prev_h   <= hdr_q;
            has_prev <= 1'b1;
            pos      <= pos_adv;
            step_cnt <= step_cnt + CNTW'(1);
          end
        end

        S_REL_NX: begin
          // hdr_q holds the header after the released block
          w0_en       <= 1'b1;
          wa0         <= start;
          wd0         <= {1'b1, LEN_W'(cur_w + (nfree ? h_len : '0))};
          w1_en       <= has_prev && prev_h[LEN_W];
          wa1         <= prev_pos;
          wd1         <= {1'b1, LEN_W'(prev_len + cur_w + (nfree ? h_len : '0))};
          w_then_loc2 <= 1'b0;
          block_count <= block_count - CNTW'(nfree) - CNTW'(has_prev && prev_h[LEN_W]);
          state       <= S_W0;
        end

        S_RSZ_NX: begin
          w_then_loc2 <= 1'b0;
          if (need_w < cur_w) begin
            w0_en <= 1'b1;
            wa0   <= start;
            wd0   <= {1'b0, LEN_W'(need_w)};
            w1_en <= 1'b1;
            wa1   <= start + need_w;
            if (nfree) begin
              wd1   <= {1'b1, LEN_W'(cur_w - need_w + h_len)};
              state <= S_W0;
            end else if (cur_w - need_w > WW'(1)) begin
              wd1         <= {1'b1, LEN_W'(cur_w - need_w)};
              block_count <= block_count + CNTW'(1);
              state       <= S_W0;
            end else begin
              state <= S_DONE;
            end
          end else if (nfree && need_w <= cur_w + h_len) begin
            w1_en <= 1'b1;
            wa1   <= start;
            if (cur_w + h_len - need_w > WW'(1)) begin
              w0_en <= 1'b1;
              wa0   <= start + need_w;
              wd0   <= {1'b1, LEN_W'(cur_w + h_len - need_w)};
              wd1   <= {1'b0, LEN_W'(need_w)};
            end else begin
              w0_en       <= 1'b0;
              wd1         <= {1'b0, LEN_W'(cur_w + h_len)};
              block_count <= block_count - CNTW'(1);
            end
            state <= S_W0;
          end else begin
            // no room in place: first fit elsewhere, then release the old block
            reloc    <= 1'b1;
            mode     <= WM_FIT;
            pos      <= '0;
            step_cnt <= '0;
            has_prev <= 1'b0;
            state    <= S_WALK;
          end
        end

        S_W0: begin
          state <= S_W1;
        end

        S_W1: begin
          state <= w_then_loc2 ? S_LOC2 : S_DONE;
        end

        S_LOC2: begin
          mode     <= WM_LOC2;
          pos      <= '0;
          step_cnt <= '0;
          has_prev <= 1'b0;
          state    <= S_WALK;
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            result_addr <= res_addr;
            status      <= res_status;
            moved       <= res_moved;
            copy_bytes  <= res_copy;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/ffha_checker.sv @@
// Port-level checks for the allocator, bound to the top level.
`timescale 1ns / 1ps
module ffha_checker
  import ffha_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] result_addr,
  input logic [1:0]        status,
  input logic              moved,
  input logic [ADDR_W-1:0] copy_bytes
);
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input valid dropped before transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_addr) && $stable(status))
    else $error("result changed while stalled");

  a_moved_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && moved |-> status == STAT_OK && result_addr != '0)
    else $error("move reported without a granted block");

  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> result_addr == '0)
    else $error("failed request returned an address");

  a_copy_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !moved |-> copy_bytes == '0)
    else $error("copy count without a move");
endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (.*);

@@ bench/tb.sv @@
// Self-checking testbench for first_fit_heap_allocator_unit.
`timescale 1ns / 1ps
module tb;
  import ffha_pkg::*;

  localparam int ZONE_GR  = 8192;
  localparam logic [31:0] HFREE = 32'h8000_0000;
  localparam logic [31:0] HLEN  = 32'h7fff_ffff;

  typedef struct {
    logic [15:0] addr;
    status_t     st;
    logic        mv;
    logic [15:0] copy;
  } alloc_res_t;

  typedef struct {
    req_type_t   kind;
    logic [15:0] size;
    logic [15:0] addr;
    bit          typed;
    alloc_res_t  want;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_ready = 0;
  logic [1:0] req_type = '0;
  logic [15:0] req_size = '0;
  logic [15:0] req_addr = '0;
  logic in_ready, out_valid, moved;
  logic [15:0] result_addr, copy_bytes;
  logic [1:0] status;

  first_fit_heap_allocator_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .req_size(req_size), .req_addr(req_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_addr(result_addr), .status(status), .moved(moved), .copy_bytes(copy_bytes)
  );

  always #10 clk = ~clk;

  // predictor state: shadow header chain
  logic [31:0] shadow_hdr [0:ZONE_GR-1];
  int unsigned shadow_blocks;

  alloc_res_t pending_q[$];
  logic [15:0] live_addrs[$];
  stim_row_t rows[$];
  int mismatches = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  bit draining = 0;

  function automatic logic [31:0] hdr_rd(int unsigned g);
    return g < ZONE_GR ? shadow_hdr[g] : 32'd0;
  endfunction

  function automatic void hdr_wr(int unsigned g, logic [31:0] v);
    if (g < ZONE_GR) shadow_hdr[g] = v;
  endfunction

  function automatic bit find_block(int unsigned target, output int unsigned prev,
                                    output bit has_prev);
    int unsigned pos, len;
    pos = 0; prev = 0; has_prev = 0;
    for (int unsigned i = 0; i < shadow_blocks && pos < ZONE_GR; i++) begin
      if (pos == target) return 1;
      prev = pos;
      has_prev = 1;
      len = hdr_rd(pos) & HLEN;
      if (len == 0) break;
      pos += len;
    end
    return 0;
  endfunction

  function automatic bit next_free(int unsigned start);
    int unsigned nxt;
    nxt = start + (hdr_rd(start) & HLEN);
    return nxt < ZONE_GR && ((hdr_rd(nxt) & HFREE) != 0);
  endfunction

  function automatic bit first_fit(int unsigned need, output int unsigned where);
    int unsigned pos, len, rem;
    logic [31:0] h;
    pos = 0; where = 0;
    for (int unsigned i = 0; i < shadow_blocks && pos < ZONE_GR; i++) begin
      h = hdr_rd(pos);
      len = h & HLEN;
      if (h[31] && need <= len) begin
        rem = len - need;
        if (rem > 1) begin
          hdr_wr(pos + need, HFREE | rem);
          shadow_blocks++;
          hdr_wr(pos, need);
        end else begin
          hdr_wr(pos, len);
        end
        where = pos;
        return 1;
      end
      if (len == 0) break;
      pos += len;
    end
    return 0;
  endfunction

  function automatic void free_block(int unsigned start, int unsigned prev, bit has_prev);
    int unsigned len, nxt;
    len = hdr_rd(start) & HLEN;
    nxt = start + len;
    if (nxt < ZONE_GR && ((hdr_rd(nxt) & HFREE) != 0)) begin
      len += hdr_rd(nxt) & HLEN;
      shadow_blocks--;
    end
    hdr_wr(start, HFREE | len);
    if (has_prev && ((hdr_rd(prev) & HFREE) != 0)) begin
      hdr_wr(prev, HFREE | ((hdr_rd(prev) & HLEN) + len));
      shadow_blocks--;
    end
  endfunction

  function automatic logic [15:0] payload_of(int unsigned start);
    return 16'((start + 1) * 8);
  endfunction

  function automatic alloc_res_t predict_alloc(logic [1:0] kind, logic [15:0] size,
                                               logic [15:0] addr);
    alloc_res_t r;
    int unsigned need, start, prev, cur, nlen, total, rem, where;
    bit has_prev, ok;
    r = '{addr: 16'd0, st: STAT_OK, mv: 1'b0, copy: 16'd0};
    need = (int'(size) + 15) / 8;
    start = 0; prev = 0; has_prev = 0; ok = 0;
    if (kind == REQ_NONE) begin
      r.st = STAT_IGNORED;
      return r;
    end
    if (kind != REQ_ALLOC && addr != 0 && addr[2:0] == 0) begin
      start = addr / 8 - 1;
      ok = find_block(start, prev, has_prev) && ((hdr_rd(start) & HFREE) == 0);
    end
    if (kind == REQ_ALLOC || (kind == REQ_RESIZE && addr == 0)) begin
      if (size == 0) r.st = STAT_ZERO;
      else if (first_fit(need, where)) r.addr = payload_of(where);
      else r.st = STAT_NOSPACE;
      return r;
    end
    if (!ok) begin
      r.st = STAT_IGNORED;
      return r;
    end
    if (kind == REQ_FREE) begin
      free_block(start, prev, has_prev);
      return r;
    end
    if (size == 0) begin
      free_block(start, prev, has_prev);
      r.st = STAT_ZERO;
      return r;
    end
    cur = hdr_rd(start) & HLEN;
    r.addr = addr;
    if (need == cur) return r;
    if (need < cur) begin
      rem = cur - need;
      if (next_free(start)) begin
        nlen = hdr_rd(start + cur) & HLEN;
        hdr_wr(start, need);
        hdr_wr(start + need, HFREE | (rem + nlen));
      end else if (rem > 1) begin
        hdr_wr(start, need);
        hdr_wr(start + need, HFREE | rem);
        shadow_blocks++;
      end
      return r;
    end
    if (next_free(start)) begin
      nlen = hdr_rd(start + cur) & HLEN;
      total = cur + nlen;
      if (need <= total) begin
        rem = total - need;
        if (rem > 1) begin
          hdr_wr(start + need, HFREE | rem);
          hdr_wr(start, need);
        end else begin
          hdr_wr(start, total);
          shadow_blocks--;
        end
        return r;
      end
    end
    if (!first_fit(need, where)) begin
      r.addr = 0;
      r.st = STAT_NOSPACE;
      return r;
    end
    if (find_block(start, prev, has_prev)) free_block(start, prev, has_prev);
    r.addr = payload_of(where);
    r.mv = 1'b1;
    r.copy = 16'((cur - 1) * 8);
    return r;
  endfunction

  // keep the list of handed-out payloads in step with the prediction
  function automatic void track_live(logic [1:0] kind, logic [15:0] addr, alloc_res_t r);
    int idx[$];
    if (kind != REQ_ALLOC && addr != 0 && (r.st == STAT_OK || r.st == STAT_ZERO)
        && !(kind == REQ_RESIZE && r.addr == addr)) begin
      idx = live_addrs.find_first_index(x) with (x == addr);
      if (idx.size() > 0) live_addrs.delete(idx[0]);
    end
    if (r.st == STAT_OK && r.addr != 0 && !(kind == REQ_RESIZE && r.addr == addr))
      live_addrs.push_back(r.addr);
  endfunction

  task automatic send_req(logic [1:0] kind, logic [15:0] size, logic [15:0] addr,
                          bit typed, alloc_res_t want);
    alloc_res_t r;
    while ($urandom_range(99) < gap_pct) @(negedge clk);
    in_valid = 1;
    req_type = kind;
    req_size = size;
    req_addr = addr;
    do @(posedge clk); while (!in_ready);
    r = predict_alloc(kind, size, addr);
    track_live(kind, addr, r);
    pending_q.push_back(typed ? want : r);
    @(negedge clk);
    in_valid = 0;
  endtask

  function automatic void add_row(req_type_t kind, logic [15:0] size, logic [15:0] addr,
                                  bit typed = 0, logic [15:0] ra = 0,
                                  status_t st = STAT_OK);
    stim_row_t s;
    s.kind = kind; s.size = size; s.addr = addr; s.typed = typed;
    s.want = '{addr: ra, st: st, mv: 1'b0, copy: 16'd0};
    rows.push_back(s);
  endfunction

  // receiver stalls
  initial begin
    forever begin
      @(negedge clk);
      out_ready = draining || ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    alloc_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result addr=%h status=%0d moved=%b copy=%h",
                   result_addr, status, moved, copy_bytes);
      end else begin
        e = pending_q.pop_front();
        if (result_addr !== e.addr || status !== e.st || moved !== e.mv
            || copy_bytes !== e.copy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp addr=%h st=%0d mv=%b cp=%h got addr=%h st=%0d mv=%b cp=%h",
                     e.addr, e.st, e.mv, e.copy, result_addr, status, moved, copy_bytes);
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    alloc_res_t dummy;
    logic [1:0] kind;
    logic [15:0] size, addr;
    int pick;
    dummy = '{addr: 16'd0, st: STAT_OK, mv: 1'b0, copy: 16'd0};
    for (int i = 0; i < ZONE_GR; i++) shadow_hdr[i] = 32'd0;
    shadow_hdr[0] = HFREE | ZONE_GR;
    shadow_blocks = 1;

    add_row(REQ_ALLOC, 16'd0, 16'd0, 1, 16'd0, STAT_ZERO);
    add_row(REQ_ALLOC, 16'hffff, 16'd0, 1, 16'd0, STAT_NOSPACE);
    add_row(REQ_FREE, 16'd0, 16'd0, 1, 16'd0, STAT_IGNORED);
    add_row(REQ_NONE, 16'hffff, 16'hffff, 1, 16'd0, STAT_IGNORED);
    add_row(REQ_ALLOC, 16'd1, 16'd0, 1, 16'd8, STAT_OK);
    add_row(REQ_ALLOC, 16'd8, 16'd0, 1, 16'd24, STAT_OK);
    add_row(REQ_FREE, 16'd0, 16'd12, 1, 16'd0, STAT_IGNORED);   // misaligned
    add_row(REQ_FREE, 16'd0, 16'd16, 1, 16'd0, STAT_IGNORED);   // inside a block
    add_row(REQ_RESIZE, 16'd8, 16'd8, 1, 16'd8, STAT_OK);       // same length
    add_row(REQ_RESIZE, 16'd40, 16'd8);                         // grow by moving
    add_row(REQ_FREE, 16'd0, 16'd24);                           // merges with prev
    add_row(REQ_FREE, 16'd0, 16'd24, 1, 16'd0, STAT_IGNORED);   // no longer a block
    add_row(REQ_RESIZE, 16'd16, 16'd0);                         // null resize allocates
    add_row(REQ_RESIZE, 16'd0, 16'd40);                         // resize to zero frees
    add_row(REQ_RESIZE, 16'd100, 16'd8);                        // grow in place
    add_row(REQ_RESIZE, 16'd8, 16'd8);                          // shrink into free next
    add_row(REQ_RESIZE, 16'hffff, 16'd8);                       // grow fails
    add_row(REQ_ALLOC, 16'd65512, 16'd0);                       // exact fit to zone end
    add_row(REQ_FREE, 16'd0, 16'd8);
    add_row(REQ_FREE, 16'd0, 16'd24);                           // next is past zone end
    add_row(REQ_ALLOC, 16'd65520, 16'd0);                       // remainder absorbed
    add_row(REQ_RESIZE, 16'd65528, 16'd8);
    add_row(REQ_RESIZE, 16'd8, 16'd8);                          // shrink, insert free tail
    add_row(REQ_FREE, 16'd0, 16'd8);
    add_row(REQ_RESIZE, 16'd8, 16'd4, 1, 16'd0, STAT_IGNORED);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (rows[i])
      send_req(rows[i].kind, rows[i].size, rows[i].addr, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 56; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 56; end
        3: begin gap_pct = 20; stall_pct = 20; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      for (int n = 0; n < 200; n++) begin
        pick = $urandom_range(99);
        if (live_addrs.size() > 60 && pick < 40) pick += 40;
        addr = 16'd0;
        if (live_addrs.size() > 0) addr = live_addrs[$urandom_range(live_addrs.size() - 1)];
        case ($urandom_range(9))
          0: size = 16'($urandom);
          1: size = 16'd0;
          2, 3: size = 16'($urandom_range(4096));
          default: size = 16'($urandom_range(200));
        endcase
        if (pick < 40) begin
          kind = REQ_ALLOC;
          addr = 16'($urandom);
        end else if (pick < 70) begin
          kind = REQ_FREE;
        end else if (pick < 95) begin
          kind = REQ_RESIZE;
        end else begin
          kind = REQ_NONE;
          addr = 16'($urandom);
        end
        // a slice of free and resize requests aim at junk addresses
        if ((kind == REQ_FREE || kind == REQ_RESIZE) && $urandom_range(9) == 0)
          addr = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
        send_req(kind, size, addr, 0, dummy);
      end
    end

    draining = 1;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
